// ===== rtl/clcg_pkg.sv =====
// Shared types, constants and codes for the combined four-LCG generator.
// No dependencies; every other file in rtl/ imports this package.
package clcg_pkg;

  localparam int unsigned NumGenerators = 128;
  localparam int unsigned GenAw = (NumGenerators > 1) ? $clog2(NumGenerators) : 1;
  localparam int unsigned NumLcg = 4;
  localparam int unsigned CfgAw = 3;

  typedef logic [30:0] seed_t;
  typedef seed_t [NumLcg-1:0] lane_vec_t;
  typedef logic [1:0] lane_t;
  typedef logic [8:0] fold_t;

  // Multipliers, moduli and the fold constants c with m = 2^31 - c.
  localparam lane_vec_t LcgMult = {31'd49689, 31'd138556, 31'd207707, 31'd45991};
  localparam lane_vec_t LcgMod = {31'd2147483323, 31'd2147483423,
                                  31'd2147483543, 31'd2147483647};
  localparam fold_t [NumLcg-1:0] LcgFold = {9'd325, 9'd225, 9'd105, 9'd1};
  localparam lane_vec_t DefaultSeeds = {31'd44444444, 31'd33333333,
                                        31'd22222222, 31'd11111111};

  typedef enum logic [3:0] {
    ModeGenerate = 4'd0,
    ModeSelect   = 4'd1,
    ModeSetSeeds = 4'd2,
    ModeInitial  = 4'd3,
    ModeNewSeed  = 4'd4,
    ModeLastSeed = 4'd5,
    ModeSetAll   = 4'd6,
    ModeRead     = 4'd7,
    ModeAdvance  = 4'd8
  } mode_e;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadSeed  = 2'd1;
  localparam logic [1:0] StatusBadIndex = 2'd2;

  localparam logic RegVExp = 1'b0;
  localparam logic RegWExp = 1'b1;

  typedef struct packed {
    logic [3:0]  mode;
    logic [6:0]  gen_index;
    logic [31:0] seed_0;
    logic [31:0] seed_1;
    logic [31:0] seed_2;
    logic [31:0] seed_3;
    logic [6:0]  advance_count;
  } in_item_t;

  typedef struct packed {
    logic [30:0] random_value;
    logic [30:0] state_0;
    logic [30:0] state_1;
    logic [30:0] state_2;
    logic [30:0] state_3;
    logic [1:0]  status;
    logic [6:0]  selected_generator;
  } out_item_t;

  // One memory row holds all seeds of one virtual generator.
  typedef struct packed {
    lane_vec_t init_s;
    lane_vec_t last_s;
    lane_vec_t cur_s;
  } row_t;

  typedef struct packed {
    logic  valid;
    lane_t lane;
    seed_t a;
    seed_t b;
  } mul_req_t;

  typedef struct packed {
    logic  valid;
    lane_t lane;
    seed_t value;
  } mul_rsp_t;

  typedef struct packed {
    logic       upd;
    logic [5:0] v_exp;
    logic [5:0] w_exp;
  } cfg_t;

endpackage

// ===== rtl/clcg_mulmod.sv =====
// Three-stage pipelined modular multiplier for the four LCG moduli.
// Depends on clcg_pkg.
module clcg_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clcg_pkg::mul_req_t req_i,
  output clcg_pkg::mul_rsp_t rsp_o
);
  import clcg_pkg::*;

  logic        s1_valid_q, s2_valid_q, s3_valid_q;
  lane_t       s1_lane_q, s2_lane_q, s3_lane_q;
  logic [61:0] s1_prod_q, s1_prod_d;
  logic [40:0] s2_fold_q, s2_fold_d;
  seed_t       s3_value_q, s3_value_d;
  logic [31:0] fold2;
  logic [31:0] mod_ext;

  // Since 2^31 = c (mod m), the high part folds down by a multiply with c.
  assign s1_prod_d = {31'd0, req_i.a} * {31'd0, req_i.b};
  assign s2_fold_d = {10'd0, s1_prod_q[61:31]} * {32'd0, LcgFold[s1_lane_q]}
                   + {10'd0, s1_prod_q[30:0]};
  assign fold2 = {22'd0, s2_fold_q[40:31]} * {23'd0, LcgFold[s2_lane_q]}
               + {1'b0, s2_fold_q[30:0]};
  assign mod_ext = {1'b0, LcgMod[s2_lane_q]};

  always_comb begin
    if (fold2 >= mod_ext) begin
      s3_value_d = seed_t'(fold2 - mod_ext);
    end else begin
      s3_value_d = fold2[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_lane_q  <= req_i.lane;
    s1_prod_q  <= s1_prod_d;
    s2_lane_q  <= s1_lane_q;
    s2_fold_q  <= s2_fold_d;
    s3_lane_q  <= s2_lane_q;
    s3_value_q <= s3_value_d;
  end

  assign rsp_o.valid = s3_valid_q;
  assign rsp_o.lane  = s3_lane_q;
  assign rsp_o.value = s3_value_q;

endmodule

// ===== rtl/clcg_seed_ram.sv =====
// Seed table: one row of initial, last and current seeds per generator.
// Synchronous write and registered read. Depends on clcg_pkg.
module clcg_seed_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [clcg_pkg::GenAw-1:0] waddr_i,
  input  clcg_pkg::row_t             wdata_i,
  input  logic                       re_i,
  input  logic [clcg_pkg::GenAw-1:0] raddr_i,
  output clcg_pkg::row_t             rdata_o
);
  import clcg_pkg::*;

  row_t mem [NumGenerators];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/clcg_apb_regs.sv =====
// APB register block holding the two jump exponents.
// Depends on clcg_pkg.
module clcg_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [clcg_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output clcg_pkg::cfg_t             cfg_o
);
  import clcg_pkg::*;

  logic [5:0] v_exp_q, w_exp_q;
  logic       wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_exp_q <= 6'd31;
      w_exp_q <= 6'd41;
    end else if (wr_en) begin
      if (paddr[2] == RegWExp) begin
        w_exp_q <= pwdata[5:0];
      end else begin
        v_exp_q <= pwdata[5:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegWExp) ? {26'd0, w_exp_q} : {26'd0, v_exp_q};

  assign cfg_o.upd   = wr_en;
  assign cfg_o.v_exp = v_exp_q;
  assign cfg_o.w_exp = w_exp_q;

endmodule

// ===== rtl/combined_lcg4_random_generator.sv =====
// Top level of the combined four-LCG generator with a table of virtual generators.
// Depends on clcg_pkg, clcg_mulmod, clcg_seed_ram and clcg_apb_regs.

// One item is taken at a time, and every item yields exactly one result beat.
// All seeds live in one synchronous memory with one row per generator; an
// operation reads the row, works on it, and writes it back when it changes
// the seeds. All modular products go through one pipelined multiplier; the
// four LCG lanes are issued back to back as one batch of four products.
// Advance first squares the running power once for each of its k steps, and
// set all rebuilds the whole table, writing each row and then multiplying by
// the generator spacing for the next. A write to either exponent register
// recomputes both jump multipliers, during which the input is stalled. After
// reset the block first computes the multipliers and then sweeps the table
// with the default seeds before it takes its first item.
module combined_lcg4_random_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  clcg_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output clcg_pkg::out_item_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [clcg_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import clcg_pkg::*;

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StCfgChk  = 11'b000_0000_0010,
    StCfgSq   = 11'b000_0000_0100,
    StFillWr  = 11'b000_0000_1000,
    StFillMul = 11'b000_0001_0000,
    StLoad    = 11'b000_0010_0000,
    StAdvChk  = 11'b000_0100_0000,
    StAdvSq   = 11'b000_1000_0000,
    StMul     = 11'b001_0000_0000,
    StWrite   = 11'b010_0000_0000,
    StOut     = 11'b100_0000_0000
  } state_e;

  state_e    state_q, state_d;
  logic      pend_q, pend_d;
  logic      init_q, init_d;
  lane_vec_t acc_q, acc_d;
  logic [6:0] step_q, step_d;
  lane_vec_t sjm_q, sjm_d;
  lane_vec_t gjm_q, gjm_d;
  lane_vec_t prev_q, prev_d;
  lane_vec_t res_q, res_d;
  logic [GenAw-1:0] fill_row_q, fill_row_d;
  row_t      row_q, row_d;
  in_item_t  item_q, item_d;
  logic [1:0] status_q, status_d;
  logic [6:0] cur_gen_q, cur_gen_d;
  logic [2:0] issue_cnt_q, issue_cnt_d;
  logic [1:0] got_cnt_q, got_cnt_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  cfg_t      cfg;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  logic      mem_we, mem_re;
  logic [GenAw-1:0] mem_waddr, mem_raddr;
  row_t      mem_wdata, mem_rdata;

  logic      in_accept;
  logic      mul_state;
  logic      batch_done;
  lane_vec_t res_all;
  lane_vec_t item_seeds;
  lane_t     issue_lane;
  logic      idx_ok;
  logic [30:0] rnd;

  clcg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clcg_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  clcg_seed_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // A seed set is usable only if every seed lies in 1..m_j-1.
  function automatic logic seeds_ok(input in_item_t it);
    logic [3:0][31:0] s;
    logic ok;
    s  = {it.seed_3, it.seed_2, it.seed_1, it.seed_0};
    ok = 1'b1;
    for (int j = 0; j < NumLcg; j++) begin
      if (s[j] == 32'd0 || s[j] >= {1'b0, LcgMod[j]}) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Combined output (x0 - x1 + x2 - x3) mod m0, built from two partial
  // differences that each stay within one modulus.
  function automatic logic [30:0] combine(input lane_vec_t c);
    logic [31:0] d1, d2, s;
    d1 = {1'b0, c[0]} - {1'b0, c[1]};
    if (d1[31]) begin
      d1 = d1 + {1'b0, LcgMod[0]};
    end
    d2 = {1'b0, c[2]} - {1'b0, c[3]};
    if (d2[31]) begin
      d2 = d2 + {1'b0, LcgMod[0]};
    end
    s = d1 + d2;
    if (s >= {1'b0, LcgMod[0]}) begin
      s = s - {1'b0, LcgMod[0]};
    end
    return s[30:0];
  endfunction

  assign in_stall_o = (state_q != StIdle) || pend_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign item_seeds = {item_q.seed_3[30:0], item_q.seed_2[30:0],
                       item_q.seed_1[30:0], item_q.seed_0[30:0]};
  assign idx_ok     = 32'(in_data_i.gen_index) < NumGenerators;
  assign rnd        = combine(row_q.cur_s);

  // The memory is read at accept time so the row is ready in the load state.
  assign mem_re    = in_accept;
  assign mem_raddr = (in_data_i.mode == ModeSelect && idx_ok) ?
                     GenAw'(in_data_i.gen_index) : GenAw'(cur_gen_q);
  assign mem_we    = (state_q == StWrite) || (state_q == StFillWr);
  assign mem_waddr = (state_q == StFillWr) ? fill_row_q : GenAw'(cur_gen_q);
  assign mem_wdata = (state_q == StFillWr) ? row_t'({prev_q, prev_q, prev_q}) : row_q;

  // Multiplier batches: four lanes issued on consecutive cycles.
  assign mul_state  = (state_q == StCfgSq) || (state_q == StAdvSq) ||
                      (state_q == StFillMul) || (state_q == StMul);
  assign issue_lane = issue_cnt_q[1:0];
  assign batch_done = mul_rsp.valid && (got_cnt_q == 2'd3);

  always_comb begin
    mul_req.valid = mul_state && !issue_cnt_q[2];
    mul_req.lane  = issue_lane;
    mul_req.a     = acc_q[issue_lane];
    mul_req.b     = acc_q[issue_lane];
    priority if (state_q == StFillMul) begin
      mul_req.a = gjm_q[issue_lane];
      mul_req.b = prev_q[issue_lane];
    end else if (state_q == StMul) begin
      if (item_q.mode == ModeGenerate) begin
        mul_req.a = LcgMult[issue_lane];
        mul_req.b = row_q.cur_s[issue_lane];
      end else if (item_q.mode == ModeNewSeed) begin
        mul_req.a = sjm_q[issue_lane];
        mul_req.b = row_q.last_s[issue_lane];
      end else begin
        mul_req.b = row_q.cur_s[issue_lane];
      end
    end else begin
      // Squaring of the running power.
    end
  end

  always_comb begin
    res_all = res_q;
    if (mul_rsp.valid) begin
      res_all[mul_rsp.lane] = mul_rsp.value;
    end
  end

  always_comb begin
    res_d       = res_all;
    got_cnt_d   = mul_rsp.valid ? got_cnt_q + 2'd1 : got_cnt_q;
    issue_cnt_d = issue_cnt_q;
    if (batch_done) begin
      issue_cnt_d = 3'd0;
    end else if (mul_req.valid) begin
      issue_cnt_d = issue_cnt_q + 3'd1;
    end
  end

  // Main sequencer.
  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q | cfg.upd;
    init_d     = init_q;
    acc_d      = acc_q;
    step_d     = step_q;
    sjm_d      = sjm_q;
    gjm_d      = gjm_q;
    prev_d     = prev_q;
    fill_row_d = fill_row_q;
    row_d      = row_q;
    item_d     = item_q;
    status_d   = status_q;
    cur_gen_d  = cur_gen_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (pend_q) begin
          pend_d  = cfg.upd;
          acc_d   = LcgMult;
          step_d  = 7'd0;
          state_d = StCfgChk;
        end else if (in_accept) begin
          item_d   = in_data_i;
          status_d = StatusOk;
          state_d  = StLoad;
        end
      end

      // The running power a^(2^step) is tapped at w for the seed jump and
      // at v+w for the generator spacing.
      StCfgChk: begin
        if (step_q == {1'b0, cfg.w_exp}) begin
          sjm_d = acc_q;
        end
        if (step_q == 7'({1'b0, cfg.w_exp} + {1'b0, cfg.v_exp})) begin
          gjm_d = acc_q;
          if (pend_q) begin
            pend_d = cfg.upd;
            acc_d  = LcgMult;
            step_d = 7'd0;
          end else if (init_q) begin
            prev_d     = DefaultSeeds;
            fill_row_d = '0;
            state_d    = StFillWr;
          end else begin
            state_d = StIdle;
          end
        end else begin
          state_d = StCfgSq;
        end
      end

      StCfgSq: begin
        if (batch_done) begin
          acc_d   = res_all;
          step_d  = step_q + 7'd1;
          state_d = StCfgChk;
        end
      end

      StFillWr: begin
        if (fill_row_q == GenAw'(cur_gen_q)) begin
          row_d = {prev_q, prev_q, prev_q};
        end
        if (fill_row_q == GenAw'(NumGenerators - 1)) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = StIdle;
          end else begin
            state_d = StOut;
          end
        end else begin
          fill_row_d = fill_row_q + 1'b1;
          state_d    = StFillMul;
        end
      end

      StFillMul: begin
        if (batch_done) begin
          prev_d  = res_all;
          state_d = StFillWr;
        end
      end

      StLoad: begin
        row_d   = mem_rdata;
        state_d = StOut;
        unique case (mode_e'(item_q.mode))
          ModeGenerate, ModeNewSeed: begin
            state_d = StMul;
          end
          ModeSelect: begin
            if (32'(item_q.gen_index) < NumGenerators) begin
              cur_gen_d = item_q.gen_index;
            end else begin
              status_d = StatusBadIndex;
            end
          end
          ModeSetSeeds: begin
            if (seeds_ok(item_q)) begin
              row_d   = {item_seeds, item_seeds, item_seeds};
              state_d = StWrite;
            end else begin
              status_d = StatusBadSeed;
            end
          end
          ModeInitial: begin
            row_d.last_s = mem_rdata.init_s;
            row_d.cur_s  = mem_rdata.init_s;
            state_d      = StWrite;
          end
          ModeLastSeed: begin
            row_d.cur_s = mem_rdata.last_s;
            state_d     = StWrite;
          end
          ModeSetAll: begin
            if (seeds_ok(item_q)) begin
              prev_d     = item_seeds;
              fill_row_d = '0;
              state_d    = StFillWr;
            end else begin
              status_d = StatusBadSeed;
            end
          end
          ModeAdvance: begin
            acc_d   = LcgMult;
            step_d  = 7'd0;
            state_d = StAdvChk;
          end
          default: begin
            // Read and unused codes leave the state alone.
          end
        endcase
      end

      StAdvChk: begin
        state_d = (step_q == item_q.advance_count) ? StMul : StAdvSq;
      end

      StAdvSq: begin
        if (batch_done) begin
          acc_d   = res_all;
          step_d  = step_q + 7'd1;
          state_d = StAdvChk;
        end
      end

      StMul: begin
        if (batch_done) begin
          state_d = StWrite;
          if (item_q.mode == ModeGenerate) begin
            row_d.cur_s = res_all;
          end else if (item_q.mode == ModeNewSeed) begin
            row_d.last_s = res_all;
            row_d.cur_s  = res_all;
          end else begin
            row_d = {res_all, res_all, res_all};
          end
        end
      end

      StWrite: begin
        state_d = StOut;
      end

      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.random_value       = (item_q.mode == ModeGenerate) ? rnd : 31'd0;
          out_d.state_0            = row_q.cur_s[0];
          out_d.state_1            = row_q.cur_s[1];
          out_d.state_2            = row_q.cur_s[2];
          out_d.state_3            = row_q.cur_s[3];
          out_d.status             = status_q;
          out_d.selected_generator = cur_gen_q;
          out_valid_d              = 1'b1;
          state_d                  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StCfgChk;
      pend_q      <= 1'b0;
      init_q      <= 1'b1;
      acc_q       <= LcgMult;
      step_q      <= 7'd0;
      cur_gen_q   <= 7'd0;
      issue_cnt_q <= 3'd0;
      got_cnt_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      init_q      <= init_d;
      acc_q       <= acc_d;
      step_q      <= step_d;
      cur_gen_q   <= cur_gen_d;
      issue_cnt_q <= issue_cnt_d;
      got_cnt_q   <= got_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sjm_q      <= sjm_d;
    gjm_q      <= gjm_d;
    prev_q     <= prev_d;
    res_q      <= res_d;
    fill_row_q <= fill_row_d;
    row_q      <= row_d;
    item_q     <= item_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The table is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("seed memory read and written in one cycle");

  a_gen_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_gen_q) < NumGenerators)
    else $error("selected generator beyond the table");

  a_batch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, got_cnt_q} <= issue_cnt_q)
    else $error("more products returned than issued");

  a_rsp_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.valid |-> (state_q == StCfgSq || state_q == StAdvSq ||
                       state_q == StFillMul || state_q == StMul))
    else $error("product returned outside a multiply batch");

endmodule
